>>> design/emgbp_pkg.sv
// emgbp_pkg: shared types, coefficients, sizes and command codes for the emg envelope block
// no dependencies
`timescale 1ns / 1ps

package emgbp_pkg;

    localparam int unsigned CMD_PROCESS = 0;
    localparam int unsigned CMD_CLEAR   = 1;

    // window length is a power of two so the mean is a shift
    localparam int WINDOW_LEN  = 64;
    localparam int SAMPLE_BITS = 24;

    typedef struct packed {
        logic        command;
        logic [23:0] raw_sample;
    } emgbp_in_t;

    typedef struct packed {
        logic [14:0] level_percent;
        logic [22:0] rms_level;
    } emgbp_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic       clear;
        logic       load;
        logic       sec_start;
        logic [1:0] sec_idx;
        logic [2:0] sec_phase;
        logic       win_read;
        logic       win_update;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       div_start;
        logic       div_step;
        logic       finish;
    } emgbp_cmd_t;

    typedef struct packed {
        logic is_clear;
    } emgbp_stat_t;

    // decimal coefficient scaled by 1e5, rounded to nearest with ties away from zero
    function automatic longint coef_fixed(input longint c, input int frac);
        longint m;
        longint q;
        begin
            m = (c < 0) ? -c : c;
            q = ((m <<< frac) + 64'sd50000) / 64'sd100000;
            coef_fixed = (c < 0) ? -q : q;
        end
    endfunction

    // b0 b1 b2 a1 a2 for section k, index j
    function automatic longint coef_dec(input int k, input int j);
        longint v;
        begin
            v = 0;
            case (k * 5 + j)
                0:  v = 39133;
                1:  v = 0;
                2:  v = -39133;
                3:  v = -66076;
                4:  v = 60851;
                5:  v = 39133;
                6:  v = 0;
                7:  v = -39133;
                8:  v = -153743;
                9:  v = 78413;
                10: v = 98439;
                11: v = -159181;
                12: v = 98439;
                13: v = -159181;
                14: v = 96878;
                default: v = 0;
            endcase
            coef_dec = v;
        end
    endfunction

endpackage

>>> design/emgbp_datapath.sv
// emgbp_datapath: shared multiplier biquad engine, window memory, running sum,
// bit-serial square root and restoring divider; depends on emgbp_pkg
`timescale 1ns / 1ps

module emgbp_datapath
    import emgbp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  emgbp_cmd_t  cmd,
    input  emgbp_in_t   in_item,
    input  logic [22:0] full_scale,
    output emgbp_stat_t stat,
    output emgbp_out_t  result
);

    localparam int SB     = SAMPLE_BITS;
    localparam int FB     = COEF_FRAC_BITS;
    localparam int STB    = SB + FB + 2;
    localparam int CB     = FB + 3;
    localparam int PB     = STB + CB + 2;
    localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int QB     = 2 * SB;
    localparam int SUMB   = 64;
    localparam int LOG2W  = $clog2(WINDOW_LEN);
    localparam int RB     = 32;

    // take the sample as signed
    logic signed [SB-1:0] x_in;
    assign x_in = $signed(in_item.raw_sample[SB-1:0]);
    assign stat.is_clear = in_item.command == 1'(CMD_CLEAR);

    function automatic logic signed [CB-1:0] coef(input logic [1:0] k, input int j);
        begin
            coef = CB'(coef_fixed(coef_dec(int'(k), j), FB));
        end
    endfunction

    function automatic logic signed [STB-1:0] sat_st(input logic signed [PB-1:0] v);
        logic signed [PB-1:0] hi;
        logic signed [PB-1:0] lo;
        begin
            hi = PB'((64'sd1 <<< (STB - 1)) - 1);
            lo = -PB'(64'sd1 <<< (STB - 1));
            if (v > hi) sat_st = STB'(hi);
            else if (v < lo) sat_st = STB'(lo);
            else sat_st = STB'(v);
        end
    endfunction

    logic signed [STB-1:0] s0_reg [3];
    logic signed [STB-1:0] s1_reg [3];
    logic signed [SB-1:0]  x_reg;
    logic signed [SB-1:0]  y_reg;
    logic signed [PB-1:0]  acc_reg;

    // one multiplier, operands chosen by phase, product lands in prod_reg a phase later
    // phase 0 b0*x, 1 b1*x, 3 a1*y, 4 b2*x, 5 a2*y
    logic signed [CB-1:0]  mul_c;
    logic signed [SB-1:0]  mul_v;
    logic signed [PB-1:0]  prod;
    logic signed [PB-1:0]  prod_reg;

    always_comb
    begin
        mul_v = x_reg;
        case (cmd.sec_phase)
            3'd0: mul_c = coef(cmd.sec_idx, 0);
            3'd1: mul_c = coef(cmd.sec_idx, 1);
            3'd3: begin mul_c = coef(cmd.sec_idx, 3); mul_v = y_reg; end
            3'd4: mul_c = coef(cmd.sec_idx, 2);
            3'd5: begin mul_c = coef(cmd.sec_idx, 4); mul_v = y_reg; end
            default: mul_c = '0;
        endcase
        prod = PB'(mul_c) * PB'(mul_v);
    end

    logic signed [PB-1:0] yround;
    logic signed [PB-1:0] ymax;
    logic signed [PB-1:0] ymin;
    always_comb
    begin
        yround = (acc_reg + PB'(64'sd1 <<< (FB - 1))) >>> FB;
        ymax   = PB'((64'sd1 <<< (SB - 1)) - 1);
        ymin   = -PB'(64'sd1 <<< (SB - 1));
    end

    // window and sum
    logic [QB-1:0]   win_mem [WINDOW_LEN];
    logic [QB-1:0]   old_reg;
    logic [AW-1:0]   pos_reg;
    logic [AW:0]     fill_reg;
    logic [SUMB-1:0] sum_reg;
    logic [QB-1:0]   sq_reg;
    logic [SB-1:0]   mag;
    assign mag = y_reg[SB-1] ? SB'(-y_reg) : SB'(y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.win_read)
            old_reg <= win_mem[pos_reg];
        if (cmd.win_update)
            win_mem[pos_reg] <= sq_reg;
    end

    // sqrt and divider state
    logic [SUMB-1:0] rad_reg;
    logic [RB-1:0]   root_reg;
    logic [RB+1:0]   rem_reg;
    logic [RB+15:0]  num_reg;
    logic [RB+15:0]  quo_reg;
    logic [23:0]     drem_reg;
    logic [22:0]     fs_reg;

    logic [SUMB-1:0] mean;
    logic [RB+1:0]   trial;
    logic [RB+1:0]   rem_sh;
    logic [24:0]     dtrial;

    always_comb
    begin
        mean   = sum_reg >> LOG2W;
        rem_sh = {rem_reg[RB-1:0], rad_reg[SUMB-1 -: 2]};
        trial  = {root_reg, 2'b01};
        dtrial = {drem_reg, num_reg[RB+15]} - {2'b0, fs_reg};
    end

    logic window_has_old;
    assign window_has_old = fill_reg == (AW+1)'(WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s0_reg[i] <= '0;
                s1_reg[i] <= '0;
            end
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            result   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s0_reg[i] <= '0;
                    s1_reg[i] <= '0;
                end
                pos_reg  <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
                result   <= '0;
            end
            if (cmd.win_update)
            begin
                sum_reg <= sum_reg - (window_has_old ? SUMB'(old_reg) : '0) + SUMB'(sq_reg);
                pos_reg <= (pos_reg == AW'(WINDOW_LEN - 1)) ? '0 : pos_reg + 1'b1;
                if (!window_has_old) fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.sec_start)
            begin
                case (cmd.sec_phase)
                    3'd5: s0_reg[cmd.sec_idx] <= sat_st(acc_reg);
                    3'd6: s1_reg[cmd.sec_idx] <= sat_st(acc_reg - prod_reg);
                    default: ;
                endcase
            end
            if (cmd.finish)
            begin
                result.rms_level     <= (root_reg > RB'(23'h7FFFFF)) ? 23'h7FFFFF
                                        : root_reg[22:0];
                result.level_percent <= (quo_reg > (RB+16)'(25600)) ? 15'd25600
                                        : quo_reg[14:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (cmd.load)
        begin
            x_reg <= x_in;
        end
        if (cmd.sec_start)
        begin
            case (cmd.sec_phase)
                3'd1: acc_reg <= prod_reg + PB'(s0_reg[cmd.sec_idx]);
                3'd2:
                begin
                    if (yround > ymax) y_reg <= SB'(ymax);
                    else if (yround < ymin) y_reg <= SB'(ymin);
                    else y_reg <= SB'(yround);
                    acc_reg <= prod_reg + PB'(s1_reg[cmd.sec_idx]);
                end
                3'd4: acc_reg <= acc_reg - prod_reg;
                3'd5: acc_reg <= prod_reg;
                3'd6: x_reg <= y_reg;
                default: ;
            endcase
        end
        sq_reg <= QB'(mag) * QB'(mag);
        if (cmd.sqrt_start)
        begin
            rad_reg  <= mean;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RB-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RB-2:0], 1'b0};
            end
        end
        if (cmd.div_start)
        begin
            num_reg  <= (RB+16)'(root_reg) * (RB+16)'(25600);
            fs_reg   <= (full_scale == '0) ? 23'd1 : full_scale;
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (!dtrial[24])
            begin
                drem_reg <= dtrial[23:0];
                quo_reg  <= {quo_reg[RB+14:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[22:0], num_reg[RB+15]};
                quo_reg  <= {quo_reg[RB+14:0], 1'b0};
            end
        end
    end

endmodule

>>> design/emgbp_ctrl.sv
// emgbp_ctrl: sequencer for filter sections, window update, root and divide
// depends on emgbp_pkg
`timescale 1ns / 1ps

module emgbp_ctrl
    import emgbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  emgbp_stat_t stat,
    output emgbp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEC  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_WIN  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] sec_reg, sec_next;
    logic [2:0] ph_reg, ph_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;

    // only a clear writes the result register at once, so only a clear waits on it
    assign in_ready  = state_reg == ST_IDLE && (!ov_reg || out_ready || !stat.is_clear);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        sec_next   = sec_reg;
        ph_next    = ph_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.sec_idx   = sec_reg;
        cmd.sec_phase = ph_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (stat.is_clear)
                    begin
                        cmd.clear = 1'b1;
                        ov_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        sec_next   = '0;
                        ph_next    = '0;
                        state_next = ST_SEC;
                    end
                end
            end
            ST_SEC:
            begin
                cmd.sec_start = 1'b1;
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd7)
                begin
                    if (sec_reg == 2'd2) state_next = ST_SQ;
                    else sec_next = sec_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                cmd.win_read = 1'b1;
                state_next   = ST_WIN;
            end
            ST_WIN:
            begin
                cmd.win_update = 1'b1;
                state_next     = ST_SQRT;
                cnt_next       = '0;
            end
            ST_SQRT:
            begin
                if (cnt_reg == 6'd0) cmd.sqrt_start = 1'b1;
                else cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd32)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0) cmd.div_start = 1'b1;
                else cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd48) state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
            ph_reg    <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

>>> design/emg_bandpass_notch_rms_envelope.sv
// emg_bandpass_notch_rms_envelope: top level, joins controller and datapath
// depends on emgbp_pkg, emgbp_ctrl, emgbp_datapath
//
//  channel | signals                          | transaction
//  in      | in_valid in_ready in_data        | command and raw_sample
//  out     | out_valid out_ready out_data     | level_percent and rms_level
//  cfg     | cfg_valid cfg_ready cfg_data     | full_scale write
//
// a sample is accepted only in idle and runs to the end before the next accept: the three
// biquads (8 phases each on one shared multiplier), a window read, a window write,
// the bit-serial root, the restoring divide, the result load, then idle;
// out_valid rises with the loaded result once the output is free
// a clear transaction is handled in idle: it clears the result and raises out_valid
// reset is asynchronous active low; filter state, window fill count and sum clear
// a waiting result holds off only a clear; a sample runs and waits in its last state
`timescale 1ns / 1ps

module emg_bandpass_notch_rms_envelope
    import emgbp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  emgbp_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output emgbp_out_t  out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [22:0] cfg_data
);

    logic [22:0] full_scale_reg;
    emgbp_cmd_t  cmd;
    emgbp_stat_t stat;

    // config register always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_scale_reg <= 23'h7FFFFF;
        else if (cfg_valid)
            full_scale_reg <= cfg_data;
    end

    emgbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    emgbp_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_item    (in_data),
        .full_scale (full_scale_reg),
        .stat       (stat),
        .result     (out_data)
    );

endmodule
